FILE: sv/gam_pkg.sv
// Shared types, widths and codes for the geo area membership core.
package gam_pkg;

   // Field and datapath widths
   localparam int unsigned POS_W  = 20;              // x_pos, y_pos, geo_value
   localparam int unsigned TRIG_W = 16;              // cos/sin, Q2.14
   localparam int unsigned HALF_W = 16;              // radius and half-axes, meters
   localparam int unsigned PROD_W = POS_W + TRIG_W;  // one rotation product
   localparam int unsigned ROT_W  = PROD_W + 1;      // rotated coordinate
   localparam int unsigned MAG_W  = PROD_W;          // |rotated coordinate|
   localparam int unsigned QUO_W  = 18;              // |u| in Q16, up to 3.0
   localparam int unsigned SQ_W   = 2 * QUO_W;       // |u|^2 in Q32
   localparam int unsigned FRAC_W = 16;              // Q16 fraction bits
   localparam int unsigned TERM_W = SQ_W - FRAC_W;   // u^2 in Q16
   localparam int unsigned FSUM_W = 22;              // unsaturated F

   // Configuration port
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;

   // Pipeline depth per section
   localparam int unsigned ROT_STAGES = 3;
   localparam int unsigned DIV_STAGES = QUO_W + 2;
   localparam int unsigned CMB_STAGES = 3;
   localparam int unsigned LATENCY    = ROT_STAGES + DIV_STAGES + CMB_STAGES;

   // Constants
   localparam logic [QUO_W-1:0]         RATIO_CLAMP = 18'd196608;  // 3.0 in Q16
   localparam logic signed [FSUM_W-1:0] ONE_Q16     = 22'sd65536;  // 1.0 in Q16
   localparam logic signed [POS_W-1:0]  SAT_MIN     = 20'h80000;   // -8.0 in Q4.16

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_KIND = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_A     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_B     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ZENITH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ZENITH = 3'd4;

   // Shape codes; the unused code behaves as an ellipse
   localparam logic [1:0] SHAPE_CIRCLE  = 2'd0;
   localparam logic [1:0] SHAPE_RECT    = 2'd1;
   localparam logic [1:0] SHAPE_ELLIPSE = 2'd2;

   typedef struct packed {
      logic signed [POS_W-1:0] x_pos;
      logic signed [POS_W-1:0] y_pos;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] geo_value;
      logic                    inside_res;
      logic                    degenerate;
   } rsp_type;

endpackage

FILE: sv/geo_area_membership_core.sv
// Top level of the geo area membership core: registers, pipeline sections and checks.
//
// Geo area membership core. Give it a point as a signed east/north offset from the
// area centre in quarter meters (start high while busy is low) and, at the end of the
// pipeline, it strobes rsp_strobe for one cycle with the area geometric function
// F in Q4.16 (saturated at -8.0), an inside-or-border flag (F >= 0) and a degenerate
// flag for a zero radius or half-axis. A new word may be started in every cycle while
// busy is low; the pipeline has no backpressure, so the receiver must take each result
// in the cycle it is strobed. The depth is set by the exact division of each rotated
// coordinate by its half-length: an 18-stage restoring divider, one quotient bit per
// stage, plus an overflow stage and a clamp stage, behind three stages of rotation
// (products, sums, magnitudes) and ahead of three stages of squaring, per-axis terms
// and shape combine with saturation. busy is high only while reset is applied. Write
// the shape, half-axes and rotation cosine and sine through the csr_ port only while
// no word is in flight; the pipeline sections read the registers directly.
module geo_area_membership_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  gam_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output gam_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [gam_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gam_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   localparam int unsigned Latency = gam_pkg::LATENCY;

   // configuration registers
   logic [1:0]                          shape_kind_ff;
   logic [gam_pkg::HALF_W-1:0]          half_a_ff;
   logic [gam_pkg::HALF_W-1:0]          half_b_ff;
   logic signed [gam_pkg::TRIG_W-1:0]   cos_zenith_ff;
   logic signed [gam_pkg::TRIG_W-1:0]   sin_zenith_ff;

   logic                                accept;
   logic [gam_pkg::HALF_W-1:0]          half_y;
   logic                                degenerate;

   logic                                rot_valid;
   logic [gam_pkg::MAG_W-1:0]           mag_x;
   logic [gam_pkg::MAG_W-1:0]           mag_y;
   logic                                div_x_valid;
   logic                                div_y_valid;
   logic [gam_pkg::QUO_W-1:0]           ratio_x;
   logic [gam_pkg::QUO_W-1:0]           ratio_y;

   // Hold off starts only while reset is applied; otherwise take a word every cycle.
   assign busy   = reset;
   assign accept = start & ~busy;

   // Write a register on csr_we; drop writes to indexes past the last register.
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_kind_ff <= gam_pkg::SHAPE_CIRCLE;
         half_a_ff     <= '0;
         half_b_ff     <= '0;
         cos_zenith_ff <= 16'sd16384;
         sin_zenith_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            gam_pkg::CSR_SHAPE_KIND: shape_kind_ff <= csr_wdata[1:0];
            gam_pkg::CSR_HALF_A:     half_a_ff     <= csr_wdata;
            gam_pkg::CSR_HALF_B:     half_b_ff     <= csr_wdata;
            gam_pkg::CSR_COS_ZENITH: cos_zenith_ff <= $signed(csr_wdata);
            gam_pkg::CSR_SIN_ZENITH: sin_zenith_ff <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // A circle uses its radius on both axes.
   assign half_y = (shape_kind_ff == gam_pkg::SHAPE_CIRCLE) ? half_a_ff : half_b_ff;

   // A zero half-length forces the saturated minimum; its divider output is ignored.
   assign degenerate = (half_a_ff == '0) || (half_y == '0);

   // Rotate into the shape frame: X = c*x + s*y, Y = c*y - s*x, then take magnitudes.
   gam_rotate u_rotate (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_data    (req_data),
      .cos_zenith (cos_zenith_ff),
      .sin_zenith (sin_zenith_ff),
      .out_valid  (rot_valid),
      .mag_x      (mag_x),
      .mag_y      (mag_y)
   );

   // Divide each magnitude by its half-length; both dividers advance in lockstep.
   gam_divider u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .dividend  (mag_x),
      .divisor   (half_a_ff),
      .out_valid (div_x_valid),
      .ratio     (ratio_x)
   );

   gam_divider u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .dividend  (mag_y),
      .divisor   (half_y),
      .out_valid (div_y_valid),
      .ratio     (ratio_y)
   );

   // Square the ratios, form F for the shape, saturate and register the result word.
   gam_combine u_combine (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_x_valid),
      .ratio_x    (ratio_x),
      .ratio_y    (ratio_y),
      .shape_kind (shape_kind_ff),
      .degenerate (degenerate),
      .out_valid  (rsp_strobe),
      .out_data   (rsp_data)
   );

   // Both dividers carry the same words.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      div_x_valid == div_y_valid)
      else $error("divider valid bits out of step");

   // Every accepted word yields its result a fixed number of cycles later.
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##Latency rsp_strobe)
      else $error("result strobe missing after accepted word");

   // A degenerate area always reports the saturated minimum and outside.
   a_degenerate_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.degenerate |->
         (rsp_data.geo_value == gam_pkg::SAT_MIN) && !rsp_data.inside_res)
      else $error("degenerate result not saturated");

   // F never exceeds 1.0.
   a_value_ceiling: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.geo_value <= 20'sd65536))
      else $error("geo_value above 1.0");

endmodule

FILE: sv/gam_rotate.sv
// Rotation of the point into the shape frame and magnitude of both coordinates.
module gam_rotate (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  gam_pkg::req_type                 in_data,
   input  logic signed [gam_pkg::TRIG_W-1:0] cos_zenith,
   input  logic signed [gam_pkg::TRIG_W-1:0] sin_zenith,
   output logic                             out_valid,
   output logic [gam_pkg::MAG_W-1:0]        mag_x,
   output logic [gam_pkg::MAG_W-1:0]        mag_y
);

   localparam int unsigned ProdW   = gam_pkg::PROD_W;
   localparam int unsigned RotW    = gam_pkg::ROT_W;
   localparam int unsigned MagW    = gam_pkg::MAG_W;
   localparam int unsigned NStages = gam_pkg::ROT_STAGES;

   logic [NStages-1:0]       valid_ff, valid_in;
   logic signed [ProdW-1:0]  pcx_ff, psy_ff, pcy_ff, psx_ff;
   logic signed [ProdW-1:0]  pcx_in, psy_in, pcy_in, psx_in;
   logic signed [RotW-1:0]   xr_ff, yr_ff, xr_in, yr_in;
   logic [MagW-1:0]          mag_x_ff, mag_y_ff, mag_x_in, mag_y_in;

   always_comb begin
      valid_in = {valid_ff[NStages-2:0], in_valid};
      // stage 1: four products
      pcx_in = ProdW'(cos_zenith) * ProdW'(in_data.x_pos);
      psy_in = ProdW'(sin_zenith) * ProdW'(in_data.y_pos);
      pcy_in = ProdW'(cos_zenith) * ProdW'(in_data.y_pos);
      psx_in = ProdW'(sin_zenith) * ProdW'(in_data.x_pos);
      // stage 2: rotated coordinates
      xr_in = RotW'(pcx_ff) + RotW'(psy_ff);
      yr_in = RotW'(pcy_ff) - RotW'(psx_ff);
      // stage 3: magnitudes
      mag_x_in = xr_ff[RotW-1] ? MagW'(-xr_ff) : MagW'(xr_ff);
      mag_y_in = yr_ff[RotW-1] ? MagW'(-yr_ff) : MagW'(yr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pcx_ff   <= pcx_in;
      psy_ff   <= psy_in;
      pcy_ff   <= pcy_in;
      psx_ff   <= psx_in;
      xr_ff    <= xr_in;
      yr_ff    <= yr_in;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
   end

   assign out_valid = valid_ff[NStages-1];
   assign mag_x     = mag_x_ff;
   assign mag_y     = mag_y_ff;

endmodule

FILE: sv/gam_divider.sv
// Pipelined restoring divider: |coordinate| / half-length, one quotient bit per stage, clamped.
module gam_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [gam_pkg::MAG_W-1:0]     dividend,
   input  logic [gam_pkg::HALF_W-1:0]    divisor,
   output logic                          out_valid,
   output logic [gam_pkg::QUO_W-1:0]     ratio
);

   localparam int unsigned MagW = gam_pkg::MAG_W;
   localparam int unsigned QuoW = gam_pkg::QUO_W;

   logic [MagW-1:0] rem_ff   [0:QuoW-1];
   logic [QuoW-1:0] quo_ff   [0:QuoW];
   logic            ovf_ff   [0:QuoW];
   logic            valid_ff [0:QuoW];
   logic [MagW-1:0] limit;
   logic [QuoW-1:0] ratio_ff, ratio_in;
   logic            out_valid_ff;

   // quotient of 2^QuoW or more is past the clamp
   assign limit = MagW'({divisor, QuoW'(0)});

   always_ff @(posedge clock) begin
      rem_ff[0] <= dividend;
      quo_ff[0] <= '0;
      ovf_ff[0] <= (dividend >= limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   for (genvar k = 0; k < QuoW; k++) begin : g_step
      logic [MagW-1:0] shifted;
      logic            fits;
      logic [QuoW-1:0] quo_in;

      always_comb begin
         shifted = MagW'(divisor) << (QuoW - 1 - k);
         fits    = (rem_ff[k] >= shifted);
         quo_in  = quo_ff[k];
         quo_in[QuoW-1-k] = fits;
      end

      always_ff @(posedge clock) begin
         quo_ff[k+1] <= quo_in;
         ovf_ff[k+1] <= ovf_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      // the last remainder is not needed
      if (k < QuoW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= fits ? (rem_ff[k] - shifted) : rem_ff[k];
         end
      end
   end

   always_comb begin
      if (ovf_ff[QuoW] || (quo_ff[QuoW] > gam_pkg::RATIO_CLAMP)) begin
         ratio_in = gam_pkg::RATIO_CLAMP;
      end else begin
         ratio_in = quo_ff[QuoW];
      end
   end

   always_ff @(posedge clock) begin
      ratio_ff <= ratio_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[QuoW];
      end
   end

   assign out_valid = out_valid_ff;
   assign ratio     = ratio_ff;

endmodule

FILE: sv/gam_combine.sv
// Squares of the axis ratios, shape function, saturation and the result register.
module gam_combine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [gam_pkg::QUO_W-1:0]  ratio_x,
   input  logic [gam_pkg::QUO_W-1:0]  ratio_y,
   input  logic [1:0]                 shape_kind,
   input  logic                       degenerate,
   output logic                       out_valid,
   output gam_pkg::rsp_type           out_data
);

   localparam int unsigned SqW     = gam_pkg::SQ_W;
   localparam int unsigned FracW   = gam_pkg::FRAC_W;
   localparam int unsigned FsumW   = gam_pkg::FSUM_W;
   localparam int unsigned PosW    = gam_pkg::POS_W;
   localparam int unsigned NStages = gam_pkg::CMB_STAGES;

   logic [NStages-1:0]       valid_ff, valid_in;
   logic [SqW-1:0]           sq_x_ff, sq_y_ff, sq_x_in, sq_y_in;
   logic signed [FsumW-1:0]  fx_ff, fy_ff, fx_in, fy_in;
   logic signed [FsumW-1:0]  sum, pick, sat;
   logic signed [PosW-1:0]   geo;
   gam_pkg::rsp_type         rsp_ff, rsp_in;

   always_comb begin
      valid_in = {valid_ff[NStages-2:0], in_valid};
      // stage 1: squares in Q32
      sq_x_in = SqW'(ratio_x) * SqW'(ratio_x);
      sq_y_in = SqW'(ratio_y) * SqW'(ratio_y);
      // stage 2: per-axis terms 1 - u^2 in Q16
      fx_in = gam_pkg::ONE_Q16 - $signed(FsumW'(sq_x_ff[SqW-1:FracW]));
      fy_in = gam_pkg::ONE_Q16 - $signed(FsumW'(sq_y_ff[SqW-1:FracW]));
      // stage 3: combine per shape and saturate
      sum = fx_ff + fy_ff - gam_pkg::ONE_Q16;
      if (shape_kind == gam_pkg::SHAPE_RECT) begin
         pick = (fx_ff < fy_ff) ? fx_ff : fy_ff;
      end else begin
         pick = sum;
      end
      sat = (pick < FsumW'(gam_pkg::SAT_MIN)) ? FsumW'(gam_pkg::SAT_MIN) : pick;
      geo = degenerate ? gam_pkg::SAT_MIN : sat[PosW-1:0];
      rsp_in.geo_value  = geo;
      rsp_in.inside_res = ~geo[PosW-1];
      rsp_in.degenerate = degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      rsp_ff  <= rsp_in;
   end

   assign out_valid = valid_ff[NStages-1];
   assign out_data  = rsp_ff;

endmodule
